// ===== hdl/ise_pga_pkg.sv =====
// Shared types, widths and constants for the ISE-driven PID gain adapter.
// No dependencies; every other file in this block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ise_pga_pkg;

  // Field and state widths
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned ACC_W   = 64;
  localparam int unsigned TICK_W  = 8;

  // Serial multiplier operand widths
  localparam int unsigned MUL_A_W = 64;
  localparam int unsigned MUL_B_W = 32;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  // Default digit width of the serial multiplier (must divide MUL_B_W, below it)
  localparam int unsigned DIGIT_W_DEF = 4;

  // Q36.60 product down to Q16.16 gain delta
  localparam int unsigned Q_LSB = 44;
  localparam int unsigned Q_W   = PROD_W - 1 - Q_LSB;

  // Period scaling drops 16 fraction bits
  localparam int unsigned PER_LSB = 16;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SETPOINT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SENS_P      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SENS_I      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SENS_D      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ADAPT_AFTER = 3'd4;

  // Register reset values
  localparam logic signed [WORD_W-1:0] SETPOINT_RST    = 32'sd0;
  localparam logic signed [WORD_W-1:0] SENS_ONE_RST    = 32'sh1000_0000;
  localparam logic signed [WORD_W-1:0] SENS_D_RST      = 32'sd268;
  localparam logic        [TICK_W-1:0] ADAPT_AFTER_RST = 8'd10;
  localparam logic        [TICK_W-1:0] TICK_MAX        = 8'hFF;

  typedef struct packed {
    logic signed [WORD_W-1:0] setpoint;
    logic signed [WORD_W-1:0] sens_p;
    logic signed [WORD_W-1:0] sens_i;
    logic signed [WORD_W-1:0] sens_d;
    logic        [TICK_W-1:0] adapt_after;
  } cfg_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] sensor_value;
    logic signed [WORD_W-1:0] gain_p;
    logic signed [WORD_W-1:0] gain_i;
    logic signed [WORD_W-1:0] gain_d;
    logic        [WORD_W-1:0] sample_period;
  } in_word_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] new_gain_p;
    logic signed [WORD_W-1:0] new_gain_i;
    logic signed [WORD_W-1:0] new_gain_d;
    logic                     adapted;
  } out_word_t;

  // Sequencer to multiplier
  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  // Multiplier to sequencer
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [PROD_W-1:0] product;
  } mul_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ,
    S_PER,
    S_GP,
    S_GI,
    S_GD,
    S_DONE
  } seq_state_t;

endpackage

`default_nettype wire

// ===== hdl/ise_pga_cfg.sv =====
// Configuration register file of the gain adapter: write-only, indexed.
// Depends on ise_pga_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module ise_pga_cfg
  import ise_pga_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_data,
  output cfg_t                      cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write index; unknown indexes drop the word
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_SETPOINT:    cfg_nxt.setpoint    = cfg_data;
        CFG_IDX_SENS_P:      cfg_nxt.sens_p      = cfg_data;
        CFG_IDX_SENS_I:      cfg_nxt.sens_i      = cfg_data;
        CFG_IDX_SENS_D:      cfg_nxt.sens_d      = cfg_data;
        CFG_IDX_ADAPT_AFTER: cfg_nxt.adapt_after = cfg_data[TICK_W-1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint    <= SETPOINT_RST;
      cfg_r.sens_p      <= SENS_ONE_RST;
      cfg_r.sens_i      <= SENS_ONE_RST;
      cfg_r.sens_d      <= SENS_D_RST;
      cfg_r.adapt_after <= ADAPT_AFTER_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== hdl/ise_pga_mul.sv =====
// Digit-serial unsigned multiplier: consumes the B operand DIGIT_W bits per
// cycle against the full A operand. Depends on ise_pga_pkg for widths/structs.
`timescale 1ns / 1ps
`default_nettype none

module ise_pga_mul
  import ise_pga_pkg::*;
#(
  parameter int unsigned DIGIT_W = DIGIT_W_DEF
)
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire mul_req_t req,
  output mul_rsp_t      rsp
);

  localparam int unsigned STEPS = MUL_B_W / DIGIT_W;
  localparam int unsigned CNT_W = $clog2(STEPS + 1);
  localparam int unsigned SUM_W = MUL_A_W + DIGIT_W;

  logic [MUL_A_W-1:0] a_r;
  logic [MUL_B_W-1:0] b_r;
  logic [MUL_A_W-1:0] hi_r;
  logic [MUL_B_W-1:0] lo_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               done_r;

  logic [DIGIT_W-1:0] digit;
  logic [SUM_W-1:0]   pp;
  logic [SUM_W-1:0]   sum;

  // One partial product of A by the low digit of B, added to the upper half
  always_comb begin
    digit = b_r[DIGIT_W-1:0];
    pp    = {{DIGIT_W{1'b0}}, a_r} * {{MUL_A_W{1'b0}}, digit};
    sum   = {{DIGIT_W{1'b0}}, hi_r} + pp;
  end

  // Load operands on start; otherwise, while steps remain, shift one digit through per cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r  <= req.a;
      b_r  <= req.b;
      hi_r <= '0;
      lo_r <= '0;
    end else if (cnt_r != '0) begin
      b_r  <= b_r >> DIGIT_W;
      hi_r <= sum[SUM_W-1:DIGIT_W];
      lo_r <= {sum[DIGIT_W-1:0], lo_r[MUL_B_W-1:DIGIT_W]};
    end
  end

  // Step counter and completion pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (req.start) begin
      cnt_r  <= CNT_W'(STEPS);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - CNT_W'(1);
      done_r <= (cnt_r == CNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  assign rsp.busy    = (cnt_r != '0);
  assign rsp.done    = done_r;
  assign rsp.product = {hi_r, lo_r};

  // Completion follows the last digit step only
  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(cnt_r) == CNT_W'(1)))
    else $error("multiplier done without a final step");

endmodule

`default_nettype wire

// ===== hdl/ise_pga_seq.sv =====
// Tick sequencer: error-squared accumulation, tick counting and gain
// adaptation, driving the shared serial multiplier. Depends on ise_pga_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ise_pga_seq
  import ise_pga_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cfg_t     cfg,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_word_t in_word,
  output logic          res_valid,
  input  wire logic     res_ready,
  output out_word_t     res_word,
  output mul_req_t      mul_req,
  input  wire mul_rsp_t mul_rsp
);

  seq_state_t state_r, state_nxt;

  in_word_t         in_r, in_nxt;
  out_word_t        res_r, res_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;

  logic              accept;
  logic              adapt_now;
  logic signed [WORD_W:0] err;
  logic [WORD_W:0]   err_mag;
  logic [ACC_W-1:0]  inc;
  logic [ACC_W:0]    acc_sum;
  logic [Q_W-1:0]    q;

  // Magnitude of a signed sensitivity; the most negative value maps to 2^31
  function automatic logic [WORD_W-1:0] sens_mag(input logic signed [WORD_W-1:0] s);
    logic [WORD_W-1:0] m;
    m = s[WORD_W-1] ? WORD_W'(-s) : WORD_W'(s);
    return m;
  endfunction

  // gain -/+ delta, clipped to the signed 32-bit range
  function automatic logic signed [WORD_W-1:0] adapt_gain(
    input logic signed [WORD_W-1:0] gain,
    input logic                     neg,
    input logic [Q_W-1:0]           delta
  );
    logic signed [Q_W+1:0] g;
    logic signed [Q_W+1:0] d;
    logic signed [Q_W+1:0] r;
    logic signed [WORD_W-1:0] res;
    g = {{(Q_W+2-WORD_W){gain[WORD_W-1]}}, gain};
    d = {2'b00, delta};
    r = neg ? g + d : g - d;
    if (r[Q_W+1:WORD_W-1] == '0 || r[Q_W+1:WORD_W-1] == '1) begin
      res = r[WORD_W-1:0];
    end else if (r[Q_W+1]) begin
      res = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(WORD_W-1){1'b1}}};
    end
    return res;
  endfunction

  // Shared arithmetic terms
  always_comb begin
    accept    = in_valid && (state_r == S_IDLE);
    adapt_now = (tick_r > cfg.adapt_after);
    err       = {cfg.setpoint[WORD_W-1], cfg.setpoint} -
                {in_word.sensor_value[WORD_W-1], in_word.sensor_value};
    err_mag   = err[WORD_W] ? (WORD_W+1)'(-err) : (WORD_W+1)'(err);
    inc       = (mul_rsp.product[PROD_W-1:ACC_W+PER_LSB] != '0) ? '1 :
                mul_rsp.product[ACC_W+PER_LSB-1:PER_LSB];
    acc_sum   = {1'b0, acc_r} + {1'b0, inc};
    q         = mul_rsp.product[PROD_W-2:Q_LSB];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = adapt_now ? S_GP : S_SQ;
      S_SQ:   if (mul_rsp.done) state_nxt = S_PER;
      S_PER:  if (mul_rsp.done) state_nxt = S_DONE;
      S_GP:   if (mul_rsp.done) state_nxt = S_GI;
      S_GI:   if (mul_rsp.done) state_nxt = S_GD;
      S_GD:   if (mul_rsp.done) state_nxt = S_DONE;
      S_DONE: if (res_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs and datapath updates
  always_comb begin
    in_nxt        = in_r;
    res_nxt       = res_r;
    acc_nxt       = acc_r;
    tick_nxt      = tick_r;
    mul_req.start = 1'b0;
    mul_req.a     = acc_r;
    mul_req.b     = '0;
    in_ready      = (state_r == S_IDLE);
    res_valid     = (state_r == S_DONE);
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          in_nxt        = in_word;
          mul_req.start = 1'b1;
          if (adapt_now) begin
            // Adapt tick: first product is |sens_p| * accumulator
            res_nxt.adapted = 1'b1;
            mul_req.a       = acc_r;
            mul_req.b       = sens_mag(cfg.sens_p);
          end else begin
            // Accumulate tick: gains pass through; square the error first
            res_nxt.new_gain_p = in_word.gain_p;
            res_nxt.new_gain_i = in_word.gain_i;
            res_nxt.new_gain_d = in_word.gain_d;
            res_nxt.adapted    = 1'b0;
            mul_req.a          = {{(MUL_A_W-WORD_W){1'b0}}, err_mag[WORD_W-1:0]};
            mul_req.b          = err_mag[WORD_W-1:0];
          end
        end
      end
      S_SQ: begin
        // Scale the squared error by the sample period
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = mul_rsp.product[ACC_W-1:0];
          mul_req.b     = in_r.sample_period;
        end
      end
      S_PER: begin
        // Saturating accumulate and count the tick
        if (mul_rsp.done) begin
          acc_nxt  = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
          tick_nxt = (tick_r == TICK_MAX) ? tick_r : tick_r + TICK_W'(1);
        end
      end
      S_GP: begin
        if (mul_rsp.done) begin
          res_nxt.new_gain_p = adapt_gain(in_r.gain_p, cfg.sens_p[WORD_W-1], q);
          mul_req.start      = 1'b1;
          mul_req.b          = sens_mag(cfg.sens_i);
        end
      end
      S_GI: begin
        if (mul_rsp.done) begin
          res_nxt.new_gain_i = adapt_gain(in_r.gain_i, cfg.sens_i[WORD_W-1], q);
          mul_req.start      = 1'b1;
          mul_req.b          = sens_mag(cfg.sens_d);
        end
      end
      S_GD: begin
        // Last gain done: clear the accumulator and the tick counter
        if (mul_rsp.done) begin
          res_nxt.new_gain_d = adapt_gain(in_r.gain_d, cfg.sens_d[WORD_W-1], q);
          acc_nxt            = '0;
          tick_nxt           = '0;
        end
      end
      S_DONE: begin
        res_nxt = res_r;
      end
      default: begin
        res_nxt = res_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      acc_r   <= '0;
      tick_r  <= '0;
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
      tick_r  <= tick_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r  <= in_nxt;
    res_r <= res_nxt;
  end

  assign res_word = res_r;

  // One word at a time: no second word while the first is in flight
  a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a word is in flight");

  // The multiplier is never restarted mid-product
  a_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
    mul_req.start |-> !mul_rsp.busy)
    else $error("multiplier restarted while busy");

  // An adapted result leaves the accumulator and counter cleared
  a_adapt_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && res_r.adapted) |-> (acc_r == '0 && tick_r == '0))
    else $error("adaptation did not clear the accumulator state");

endmodule

`default_nettype wire

// ===== hdl/ise_pid_gain_adapter.sv =====
// Each input word runs through the shared digit-serial multiplier: two products
// per accumulate tick, three per adapt tick. The sequencer takes no new word
// until it has handed on the last result. An output register lets the next word
// enter while a result waits. Synchronous active-low reset restores the register
// defaults and clears the accumulator and tick counter.
`timescale 1ns / 1ps
`default_nettype none

module ise_pid_gain_adapter
  import ise_pga_pkg::*;
#(
  parameter int unsigned DIGIT_W = DIGIT_W_DEF
)
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_word_t             in_word,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_word_t                 out_word
);

  cfg_t      cfg;
  mul_req_t  mul_req;
  mul_rsp_t  mul_rsp;
  logic      res_valid;
  logic      res_ready;
  out_word_t res_word;

  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r;

  ise_pga_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ise_pga_mul #(
    .DIGIT_W (DIGIT_W)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  ise_pga_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word),
    .mul_req   (mul_req),
    .mul_rsp   (mul_rsp)
  );

  // Output register: take a finished word when empty or being drained
  always_comb begin
    res_ready     = !out_valid_r || out_ready;
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_word_r <= res_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire
